// ===== design/pulse_width_frame_receiver_assert.svh =====
// ----------------------------------------------------------------------------
// pulse_width_frame_receiver_assert
// assertion macros shared by the pulse width frame receiver
// ----------------------------------------------------------------------------
`ifndef PULSE_WIDTH_FRAME_RECEIVER_ASSERT_SVH
`define PULSE_WIDTH_FRAME_RECEIVER_ASSERT_SVH

// antecedent holds, consequent holds in the same cycle
`define PWFR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pwfr assertion failed");

// antecedent holds, consequent holds in the next cycle
`define PWFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pwfr assertion failed");

`endif

// ===== design/pwfr_pkg.sv =====
// ----------------------------------------------------------------------------
// pwfr_pkg
// types and constants of the pulse width frame receiver
// ----------------------------------------------------------------------------
package pwfr_pkg;

   localparam int FRAME_BITS_DEF  = 16;
   localparam int COUNT_WIDTH_DEF = 16;
   localparam int WORD_WIDTH      = 16;
   localparam int CSR_ADDR_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [15:0] RESET_LOW_LIMIT_RST  = 16'd1000;
   localparam logic [11:0] START_HIGH_LIMIT_RST = 12'd30;
   localparam logic [11:0] BIT_HIGH_LIMIT_RST   = 12'd40;
   localparam logic [11:0] ONE_THRESHOLD_RST    = 12'd20;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_RESET_LOW_LIMIT  = 2'd0,
      CSR_START_HIGH_LIMIT = 2'd1,
      CSR_BIT_HIGH_LIMIT   = 2'd2,
      CSR_ONE_THRESHOLD    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      FAIL_RESET_LOW  = 2'd0,
      FAIL_START_HIGH = 2'd1,
      FAIL_BIT_HIGH   = 2'd2
   } fail_phase_type;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_RESET_LOW  = 3'd1,
      PH_START_HIGH = 3'd2,
      PH_BIT_LOW    = 3'd3,
      PH_BIT_HIGH   = 3'd4,
      PH_END_LOW    = 3'd5
   } phase_type;

   typedef struct packed {
      logic [15:0] reset_low_limit;
      logic [11:0] start_high_limit;
      logic [11:0] bit_high_limit;
      logic [11:0] one_threshold;
   } cfg_type;

   typedef struct packed {
      logic                  valid;
      logic [WORD_WIDTH-1:0] frame_word;
      logic                  frame_failed;
      fail_phase_type        fail_phase;
   } result_type;

endpackage

// ===== design/pwfr_decoder.sv =====
// ----------------------------------------------------------------------------
// pwfr_decoder
// frame state machine, tick counter and bit shifter, one line sample per step
// ----------------------------------------------------------------------------
module pwfr_decoder
   import pwfr_pkg::*;
#(
   parameter int FRAME_BITS  = FRAME_BITS_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       line_level,
   input  cfg_type    cfg,
   output result_type result
);

   localparam int CMP_WIDTH  = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
   localparam int BITS_WIDTH = $clog2(FRAME_BITS + 1);
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
   localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
   localparam logic [BITS_WIDTH-1:0]  LAST_BIT = BITS_WIDTH'(FRAME_BITS - 1);

   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [BITS_WIDTH-1:0]  bits_ff, bits_in;
   logic [FRAME_BITS-1:0]  shift_ff, shift_in;

   logic [COUNT_WIDTH-1:0] count_inc;
   logic [CMP_WIDTH-1:0]   inc_w, one_w, cur_w;
   logic [CMP_WIDTH-1:0]   rl_w, sl_w, bl_w, th_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         bits_ff  <= '0;
         shift_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         bits_ff  <= bits_in;
         shift_ff <= shift_in;
      end
   end

   always_comb begin
      count_inc = (count_ff == CNT_MAX) ? count_ff : count_ff + CNT_ONE;
      inc_w = CMP_WIDTH'(count_inc);
      one_w = CMP_WIDTH'(CNT_ONE);
      cur_w = CMP_WIDTH'(count_ff);
      rl_w  = CMP_WIDTH'(cfg.reset_low_limit);
      sl_w  = CMP_WIDTH'(cfg.start_high_limit);
      bl_w  = CMP_WIDTH'(cfg.bit_high_limit);
      th_w  = CMP_WIDTH'(cfg.one_threshold);

      phase_in            = phase_ff;
      count_in            = count_ff;
      bits_in             = bits_ff;
      shift_in            = shift_ff;
      result.valid        = 1'b0;
      result.frame_word   = '0;
      result.frame_failed = 1'b0;
      result.fail_phase   = FAIL_RESET_LOW;

      unique case (phase_ff)
         PH_IDLE: begin
            if (!line_level) begin
               phase_in = PH_RESET_LOW;
               count_in = CNT_ONE;
               bits_in  = '0;
               shift_in = '0;
               if (one_w > rl_w) begin
                  phase_in            = PH_IDLE;
                  count_in            = '0;
                  result.valid        = 1'b1;
                  result.frame_failed = 1'b1;
                  result.fail_phase   = FAIL_RESET_LOW;
               end
            end
         end
         PH_RESET_LOW: begin
            if (!line_level) begin
               count_in = count_inc;
               if (inc_w > rl_w) begin
                  phase_in            = PH_IDLE;
                  count_in            = '0;
                  result.valid        = 1'b1;
                  result.frame_failed = 1'b1;
                  result.fail_phase   = FAIL_RESET_LOW;
               end
            end else begin
               phase_in = PH_START_HIGH;
               count_in = CNT_ONE;
               if (one_w > sl_w) begin
                  phase_in            = PH_IDLE;
                  count_in            = '0;
                  result.valid        = 1'b1;
                  result.frame_failed = 1'b1;
                  result.fail_phase   = FAIL_START_HIGH;
               end
            end
         end
         PH_START_HIGH: begin
            if (line_level) begin
               count_in = count_inc;
               if (inc_w > sl_w) begin
                  phase_in            = PH_IDLE;
                  count_in            = '0;
                  result.valid        = 1'b1;
                  result.frame_failed = 1'b1;
                  result.fail_phase   = FAIL_START_HIGH;
               end
            end else begin
               phase_in = PH_BIT_LOW;
               count_in = '0;
            end
         end
         PH_BIT_LOW: begin
            if (line_level) begin
               phase_in = PH_BIT_HIGH;
               count_in = CNT_ONE;
               if (one_w > bl_w) begin
                  phase_in            = PH_IDLE;
                  count_in            = '0;
                  result.valid        = 1'b1;
                  result.frame_failed = 1'b1;
                  result.fail_phase   = FAIL_BIT_HIGH;
               end
            end
         end
         PH_BIT_HIGH: begin
            if (line_level) begin
               count_in = count_inc;
               if (inc_w > bl_w) begin
                  phase_in            = PH_IDLE;
                  count_in            = '0;
                  result.valid        = 1'b1;
                  result.frame_failed = 1'b1;
                  result.fail_phase   = FAIL_BIT_HIGH;
               end
            end else begin
               shift_in = FRAME_BITS'({(cur_w > th_w), shift_ff} >> 1);
               bits_in  = bits_ff + BITS_WIDTH'(1);
               count_in = '0;
               phase_in = (bits_ff == LAST_BIT) ? PH_END_LOW : PH_BIT_LOW;
            end
         end
         PH_END_LOW: begin
            if (line_level) begin
               phase_in          = PH_IDLE;
               count_in          = '0;
               result.valid      = 1'b1;
               result.frame_word = WORD_WIDTH'(shift_ff);
            end
         end
         default: begin
            phase_in = PH_IDLE;
            count_in = '0;
         end
      endcase

      if (!step) begin
         result.valid = 1'b0;
      end
   end

endmodule

// ===== design/pulse_width_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// pulse_width_frame_receiver
// decodes a single-wire pulse width frame from one line sample per tick
//
//   port group  dir  contents
//   req_*       in   line sample word, tdata[0] line_level
//   rsp_*       out  frame result word, tdata frame_word, tuser failure flags
//   csr_*       in   limit and threshold register writes
//
// one sample word is taken every cycle while req_tready is high; a result leaves in
// the cycle after the sample that completes or aborts a frame, through a single
// output register. req_tready drops only while that register holds a word rsp does
// not take. reset is synchronous and restores the register defaults and idle phase.
// ----------------------------------------------------------------------------
module pulse_width_frame_receiver
   import pwfr_pkg::*;
#(
   parameter int FRAME_BITS  = FRAME_BITS_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,  // [0] line_level, [7:1] zero
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [WORD_WIDTH-1:0]     rsp_tdata,  // [15:0] frame_word
   output logic [2:0]                rsp_tuser,  // [0] frame_failed, [2:1] fail_phase
   input  logic                      csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   cfg_type    cfg_ff;
   result_type result;
   logic       req_accept;

   logic                  rsp_valid_ff;
   logic [WORD_WIDTH-1:0] rsp_word_ff;
   logic [2:0]            rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_limit  <= RESET_LOW_LIMIT_RST;
         cfg_ff.start_high_limit <= START_HIGH_LIMIT_RST;
         cfg_ff.bit_high_limit   <= BIT_HIGH_LIMIT_RST;
         cfg_ff.one_threshold    <= ONE_THRESHOLD_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_RESET_LOW_LIMIT:  cfg_ff.reset_low_limit  <= csr_wdata;
            CSR_START_HIGH_LIMIT: cfg_ff.start_high_limit <= csr_wdata[11:0];
            CSR_BIT_HIGH_LIMIT:   cfg_ff.bit_high_limit   <= csr_wdata[11:0];
            CSR_ONE_THRESHOLD:    cfg_ff.one_threshold    <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   pwfr_decoder #(
      .FRAME_BITS  (FRAME_BITS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_decoder (
      .clock      (clock),
      .reset      (reset),
      .step       (req_accept),
      .line_level (req_tdata[0]),
      .cfg        (cfg_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_word_ff <= result.frame_word;
         rsp_user_ff <= {result.fail_phase, result.frame_failed};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tuser  = rsp_user_ff;

`include "pulse_width_frame_receiver_assert.svh"

   `PWFR_ASSERT_SAME(a_result_needs_accept, clock, reset, result.valid, req_accept)
   `PWFR_ASSERT_SAME(a_failed_word_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0)
   `PWFR_ASSERT_SAME(a_success_phase_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tuser[2:1] == 2'd0)
   `PWFR_ASSERT_NEXT(a_result_registered, clock, reset, result.valid, rsp_tvalid)

endmodule

// ===== test/tb_pulse_width_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pulse_width_frame_receiver
// self-checking bench for the single-wire pulse width frame receiver
//
// line samples are streamed in from a queue while a behavioral decoder in the
// bench follows the same samples and predicts every frame word and every
// timeout. each result word is checked field by field against the oldest
// prediction. the run covers the default limits, the register extremes and
// a few random limit settings, with random gaps on the input and random
// stalls on the output.
// ----------------------------------------------------------------------------
module tb_pulse_width_frame_receiver;
   import pwfr_pkg::*;

   typedef struct {
      logic [WORD_WIDTH-1:0] word;
      logic                  failed;
      fail_phase_type        fail_phase;
   } frame_result_type;

   typedef enum {LEN_RANDOM, LEN_SHORTEST, LEN_LONGEST} len_style_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata  = 8'h00;  // [0] line_level, [7:1] zero
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [WORD_WIDTH-1:0]     rsp_tdata;           // [15:0] frame_word
   logic [2:0]                rsp_tuser;           // [0] frame_failed, [2:1] fail_phase
   logic                      csr_we     = 1'b0;
   csr_index_type             csr_addr   = CSR_RESET_LOW_LIMIT;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata  = '0;

   // decoder state and register copy
   cfg_type                    cfg = '{RESET_LOW_LIMIT_RST, START_HIGH_LIMIT_RST,
                                       BIT_HIGH_LIMIT_RST, ONE_THRESHOLD_RST};
   phase_type                  rx_phase = PH_IDLE;
   logic [COUNT_WIDTH_DEF-1:0] rx_ticks = '0;
   int                         rx_bits  = 0;
   logic [WORD_WIDTH-1:0]      rx_shift = '0;

   logic             line_samples[$];
   frame_result_type expected_frames[$];

   int errors         = 0;
   int samples_sent   = 0;
   int frames_ok      = 0;
   int frames_aborted = 0;
   int settings_used  = 0;
   int send_gap       = 0;
   int stall_left     = 0;
   bit sender_gaps    = 1'b1;
   bit sink_stalls    = 1'b1;
   bit line_dirty     = 1'b0;

   pulse_width_frame_receiver uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic void count_tick();
      if (rx_ticks != '1) rx_ticks++;
   endfunction

   function automatic void record_abort(input fail_phase_type why);
      expected_frames.push_back('{word: '0, failed: 1'b1, fail_phase: why});
      rx_phase = PH_IDLE;
      rx_ticks = '0;
   endfunction

   function automatic void decode_line_sample(input logic high);
      case (rx_phase)
         PH_IDLE: begin
            if (!high) begin
               rx_phase = PH_RESET_LOW;
               rx_bits  = 0;
               rx_shift = '0;
               rx_ticks = '0;
               count_tick();
               if (rx_ticks > cfg.reset_low_limit) record_abort(FAIL_RESET_LOW);
            end
         end
         PH_RESET_LOW: begin
            if (!high) begin
               count_tick();
               if (rx_ticks > cfg.reset_low_limit) record_abort(FAIL_RESET_LOW);
            end else begin
               rx_phase = PH_START_HIGH;
               rx_ticks = '0;
               count_tick();
               if (rx_ticks > cfg.start_high_limit) record_abort(FAIL_START_HIGH);
            end
         end
         PH_START_HIGH: begin
            if (high) begin
               count_tick();
               if (rx_ticks > cfg.start_high_limit) record_abort(FAIL_START_HIGH);
            end else begin
               rx_phase = PH_BIT_LOW;
               rx_ticks = '0;
            end
         end
         PH_BIT_LOW: begin
            if (high) begin
               rx_phase = PH_BIT_HIGH;
               rx_ticks = '0;
               count_tick();
               if (rx_ticks > cfg.bit_high_limit) record_abort(FAIL_BIT_HIGH);
            end
         end
         PH_BIT_HIGH: begin
            if (high) begin
               count_tick();
               if (rx_ticks > cfg.bit_high_limit) record_abort(FAIL_BIT_HIGH);
            end else begin
               rx_shift = {rx_ticks > cfg.one_threshold, rx_shift[WORD_WIDTH-1:1]};
               rx_bits++;
               rx_ticks = '0;
               rx_phase = (rx_bits >= FRAME_BITS_DEF) ? PH_END_LOW : PH_BIT_LOW;
            end
         end
         PH_END_LOW: begin
            if (high) begin
               rx_phase = PH_IDLE;
               rx_ticks = '0;
               // fail_phase reads zero on a good frame
               expected_frames.push_back('{word: rx_shift, failed: 1'b0,
                                           fail_phase: FAIL_RESET_LOW});
            end
         end
         default: begin
            rx_phase = PH_IDLE;
            rx_ticks = '0;
         end
      endcase
   endfunction

   // sample driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_line_sample(req_tdata[0]);
            samples_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (line_samples.size() > 0) begin
               req_tdata  <= {7'b0, line_samples.pop_front()};
               req_tvalid <= 1'b1;
               if (sender_gaps && $urandom_range(0, 99) < 25) send_gap = idle_len();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_frames.size() == 0) begin
               if (errors < 40)
                  $display("%0t: unexpected word, got word %h failed %b phase %0d",
                           $time, rsp_tdata, rsp_tuser[0], rsp_tuser[2:1]);
               errors++;
            end else begin
               want = expected_frames.pop_front();
               if (rsp_tdata !== want.word || rsp_tuser[0] !== want.failed ||
                   rsp_tuser[2:1] !== want.fail_phase) begin
                  if (errors < 40)
                     $display({"%0t: expected word %h failed %b phase %0d, ",
                               "got word %h failed %b phase %0d"},
                              $time, want.word, want.failed, want.fail_phase,
                              rsp_tdata, rsp_tuser[0], rsp_tuser[2:1]);
                  errors++;
               end
               if (want.failed) frames_aborted++;
               else frames_ok++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (sink_stalls && $urandom_range(0, 99) < 12) begin
            stall_left = idle_len() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_RESET_LOW_LIMIT:  cfg.reset_low_limit  = value;
         CSR_START_HIGH_LIMIT: cfg.start_high_limit = value[11:0];
         CSR_BIT_HIGH_LIMIT:   cfg.bit_high_limit   = value[11:0];
         CSR_ONE_THRESHOLD:    cfg.one_threshold    = value[11:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // upper bits of the 12 bit registers carry junk
   task automatic apply_limits(input int rl, input int sh, input int bh, input int th);
      write_csr(CSR_RESET_LOW_LIMIT, 16'(rl));
      write_csr(CSR_START_HIGH_LIMIT, {4'($urandom), 12'(sh)});
      write_csr(CSR_BIT_HIGH_LIMIT, {4'($urandom), 12'(bh)});
      write_csr(CSR_ONE_THRESHOLD, {4'($urandom), 12'(th)});
      settings_used++;
   endtask

   task automatic wait_until_quiet();
      do @(posedge clock);
      while (line_samples.size() != 0 || req_tvalid || expected_frames.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic push_run(input logic level, input int count);
      repeat (count) line_samples.push_back(level);
   endtask

   function automatic int pulse_len(input int lo, input int hi, input len_style_type how);
      int top;
      if (hi < lo) return lo;
      if (how == LEN_SHORTEST) return lo;
      if (how == LEN_LONGEST) return hi;
      top = (hi < lo + 7) ? hi : lo + 7;
      case ($urandom_range(0, 19))
         0: return (hi <= 4095) ? hi : top;
         1: return lo;
         default: return $urandom_range(lo, top);
      endcase
   endfunction

   task automatic push_frame(input logic [WORD_WIDTH-1:0] word, input len_style_type how);
      int i;
      int thr;
      int bh;
      thr = cfg.one_threshold;
      bh  = cfg.bit_high_limit;
      push_run(1'b1, $urandom_range(1, 3));
      push_run(1'b0, pulse_len(1, cfg.reset_low_limit, how));
      push_run(1'b1, pulse_len(1, cfg.start_high_limit, how));
      for (i = 0; i < FRAME_BITS_DEF; i++) begin
         push_run(1'b0, $urandom_range(1, 4));
         if (word[i] && thr < bh) push_run(1'b1, pulse_len(thr + 1, bh, how));
         else push_run(1'b1, pulse_len(1, (thr < bh) ? thr : bh, how));
      end
      push_run(1'b0, $urandom_range(1, 4));
      push_run(1'b1, 1);
   endtask

   task automatic push_overrun(input fail_phase_type where);
      push_run(1'b1, 1);
      if (where == FAIL_RESET_LOW && cfg.reset_low_limit <= 2000) begin
         push_run(1'b0, cfg.reset_low_limit + 1 + $urandom_range(0, 2));
         line_dirty = 1'b1;
      end else begin
         push_run(1'b0, pulse_len(1, cfg.reset_low_limit, LEN_RANDOM));
         if (where == FAIL_BIT_HIGH) begin
            push_run(1'b1, pulse_len(1, cfg.start_high_limit, LEN_RANDOM));
            repeat ($urandom_range(0, FRAME_BITS_DEF - 1)) begin
               push_run(1'b0, $urandom_range(1, 3));
               push_run(1'b1, pulse_len(1, cfg.bit_high_limit, LEN_RANDOM));
            end
            push_run(1'b0, $urandom_range(1, 3));
            push_run(1'b1, cfg.bit_high_limit + 1 + $urandom_range(0, 2));
         end else begin
            push_run(1'b1, cfg.start_high_limit + 1 + $urandom_range(0, 2));
         end
      end
   endtask

   task automatic push_noise();
      repeat ($urandom_range(2, 10)) push_run(1'($urandom), $urandom_range(1, 8));
      line_dirty = 1'b1;
   endtask

   task automatic push_mix(input int count);
      int r;
      repeat (count) begin
         if (line_dirty) begin
            push_run(1'b1, ((cfg.start_high_limit > cfg.bit_high_limit) ?
                            cfg.start_high_limit : cfg.bit_high_limit) + 2);
            line_dirty = 1'b0;
         end
         r = $urandom_range(0, 99);
         if (r < 65) begin
            push_frame(16'($urandom), LEN_RANDOM);
         end else if (r < 80) begin
            push_overrun(fail_phase_type'($urandom_range(0, 2)));
         end else if (r < 90) begin
            // frame cut short and followed by junk
            push_run(1'b1, 1);
            push_run(1'b0, pulse_len(1, cfg.reset_low_limit, LEN_RANDOM));
            push_run(1'b1, pulse_len(1, cfg.start_high_limit, LEN_RANDOM));
            push_noise();
         end else begin
            push_noise();
         end
      end
   endtask

   // leave the receiver idle, then drain
   task automatic finish_phase();
      if (line_dirty) begin
         push_run(1'b1, ((cfg.start_high_limit > cfg.bit_high_limit) ?
                         cfg.start_high_limit : cfg.bit_high_limit) + 2);
         line_dirty = 1'b0;
      end
      wait_until_quiet();
   endtask

   initial begin
      int bh;
      int th;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      settings_used = 1;

      // default limits
      push_run(1'b1, 3);
      push_frame(16'h0000, LEN_SHORTEST);
      push_frame(16'ha5c3, LEN_SHORTEST);
      push_overrun(FAIL_BIT_HIGH);
      finish_phase();

      apply_limits(1, 1, 1, 0);
      push_frame(16'($urandom), LEN_SHORTEST);
      push_frame(16'h8001, LEN_LONGEST);
      push_overrun(FAIL_RESET_LOW);
      push_overrun(FAIL_START_HIGH);
      push_overrun(FAIL_BIT_HIGH);
      push_mix(2);
      finish_phase();

      sender_gaps = 1'b0;
      apply_limits(65535, 4095, 4095, 4095);
      push_frame(16'($urandom), LEN_SHORTEST);
      push_frame(16'hffff, LEN_SHORTEST);
      finish_phase();
      sender_gaps = 1'b1;

      apply_limits(0, 0, 0, 0);
      push_frame(16'($urandom), LEN_RANDOM);
      push_noise();
      push_mix(2);
      finish_phase();

      apply_limits(6, 5, 8, 4095);
      push_frame(16'hffff, LEN_LONGEST);
      // reset pulse too long, the line stays low, then start pulse too long
      push_run(1'b0, cfg.reset_low_limit + 1);
      push_run(1'b0, 3);
      push_run(1'b1, cfg.start_high_limit + 1);
      push_mix(1);
      finish_phase();

      apply_limits(3, 2, 9, 9);
      push_frame(16'h1234, LEN_LONGEST);
      finish_phase();

      // random limits, mostly well-formed frames
      while (samples_sent < 1950) begin
         bh = $urandom_range(1, 12);
         th = ($urandom_range(0, 99) < 80) ? $urandom_range(0, bh) : $urandom_range(bh, bh + 20);
         apply_limits($urandom_range(1, 40), $urandom_range(1, 12), bh, th);
         sender_gaps = $urandom_range(0, 3) != 0;
         sink_stalls = $urandom_range(0, 3) != 0;
         push_mix(3);
         finish_phase();
      end

      $display("covered %0d line samples: %0d frames decoded, %0d aborted on timeouts",
               samples_sent, frames_ok, frames_aborted);
      $display("across %0d limit settings, register extremes and random limits included",
               settings_used);
      if (errors == 0) begin
         $display("** pulse_width_frame_receiver: PASSED **");
      end else begin
         $display("** pulse_width_frame_receiver: FAILED **");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("%0t: timeout with %0d results outstanding", $time, expected_frames.size());
      $display("** pulse_width_frame_receiver: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/pwfr_pkg.sv
design/pwfr_decoder.sv
design/pulse_width_frame_receiver.sv
test/tb_pulse_width_frame_receiver.sv
